[rtl/ch8_pkg.sv]
`timescale 1ns / 1ps

package ch8_pkg;

  localparam int MEM_BYTES = 4096;
  localparam int SCREEN_W = 64;
  localparam int SCREEN_H = 32;
  localparam int FONT_LEN = 80;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_EXEC = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;
  localparam logic [1:0] CMD_PIX  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_WAIT  = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;
  localparam logic [1:0] ST_FAULT = 2'd3;

  localparam logic [15:0] OP_CLS = 16'h00E0;
  localparam logic [15:0] OP_RET = 16'h00EE;
  localparam logic [7:0]  KEY_EQ = 8'h9E;
  localparam logic [7:0]  KEY_NE = 8'hA1;
  localparam logic [7:0]  F_GETDT = 8'h07;
  localparam logic [7:0]  F_WAITK = 8'h0A;
  localparam logic [7:0]  F_SETDT = 8'h15;
  localparam logic [7:0]  F_SETST = 8'h18;
  localparam logic [7:0]  F_ADDI  = 8'h1E;
  localparam logic [7:0]  F_FONT  = 8'h29;
  localparam logic [7:0]  F_BCD   = 8'h33;
  localparam logic [7:0]  F_STORE = 8'h55;
  localparam logic [7:0]  F_FETCH = 8'h65;

  localparam logic [7:0] FONT_ROM [FONT_LEN] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  typedef struct packed {
    logic [7:0] val;
    logic [7:0] vf;
    logic       vf_we;
    logic       bad;
  } alu_res_t;

endpackage

[rtl/chip8_cpu_step.sv]
`timescale 1ns / 1ps
// Channel  Direction  Handshake              Payload
// cfg      in         cfg_wr_en              cfg_wr_data (start address, also loads PC)
// in       in         in_valid / in_ready    cmd, load, key, random and pixel fields
// out      out        out_valid / out_ready  pc, status, pixel_lit, sound_active, display_changed
// Load and tick go from S_IDLE to S_DONE, a pixel read via S_PIX, an instruction via S_F1
// and S_DEC (two fetch reads). Clear screen adds S_CLS over all 32 rows, a sprite of N rows
// S_DRA and S_DRB per row, FX33 three BCD writes, FX55 X+1 writes and FX65 S_LDA and S_LDB
// per register; the single port of each memory sets this order. After reset a clearing pass
// over all 4096 addresses writes the font and zeroes both memories. A result waiting in the
// output register holds the next transaction in S_DONE until that register has been handed on.

module chip8_cpu_step #(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [11:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [11:0] in_load_address,
  input  logic [7:0]  in_load_byte,
  input  logic        in_key_down,
  input  logic [3:0]  in_key_code,
  input  logic [7:0]  in_random_byte,
  input  logic [5:0]  in_pixel_x,
  input  logic [4:0]  in_pixel_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_pc,
  output logic [1:0]  out_status,
  output logic        out_pixel_lit,
  output logic        out_sound_active,
  output logic        out_display_changed
);

  localparam int SIW = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_PIX  = 4'd2;
  localparam logic [3:0] S_F1   = 4'd3;
  localparam logic [3:0] S_DEC  = 4'd4;
  localparam logic [3:0] S_CLS  = 4'd5;
  localparam logic [3:0] S_DRA  = 4'd6;
  localparam logic [3:0] S_DRB  = 4'd7;
  localparam logic [3:0] S_BCD  = 4'd8;
  localparam logic [3:0] S_ST   = 4'd9;
  localparam logic [3:0] S_LDA  = 4'd10;
  localparam logic [3:0] S_LDB  = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  logic [3:0]     state_r, state_nxt;
  logic [11:0]    clr_r, clr_nxt;
  logic [4:0]     cnt_r, cnt_nxt;
  logic [11:0]    pc_r, pc_nxt;
  logic [15:0]    i_r, i_nxt;
  logic [7:0]     dt_r, dt_nxt;
  logic [7:0]     st_r, st_nxt;
  logic [SPW-1:0] sp_r, sp_nxt;
  logic [11:0]    stk_r [STACK_DEPTH];
  logic [11:0]    stk_nxt [STACK_DEPTH];
  logic [7:0]     v_r [16];
  logic [7:0]     v_nxt [16];
  logic [7:0]     hi_r, hi_nxt;
  logic [15:0]    op_r, op_nxt;
  logic           key_down_r, key_down_nxt;
  logic [3:0]     key_code_r, key_code_nxt;
  logic [7:0]     rnd_r, rnd_nxt;
  logic [5:0]     px_r, px_nxt;
  logic [5:0]     ox_r, ox_nxt;
  logic [4:0]     oy_r, oy_nxt;
  logic           hit_r, hit_nxt;
  logic [1:0]     status_r, status_nxt;
  logic           lit_r, lit_nxt;
  logic           drew_r, drew_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [11:0]    out_pc_r, out_pc_nxt;
  logic [1:0]     out_status_r, out_status_nxt;
  logic           out_lit_r, out_lit_nxt;
  logic           out_snd_r, out_snd_nxt;
  logic           out_drew_r, out_drew_nxt;

  logic           m_we;
  logic [11:0]    m_waddr, m_raddr;
  logic [7:0]     m_wdata, m_q;
  logic           d_we;
  logic [4:0]     d_waddr, d_raddr;
  logic [63:0]    d_wdata, d_q;

  logic [15:0]    op_w;
  logic [3:0]     x, y;
  logic [7:0]     vx, vy, nn;
  logic [11:0]    nnn, pc2, pc4;
  logic [SPW-1:0] spm1;
  logic           pressed;
  ch8_pkg::alu_res_t alu;

  logic [7:0]     bx, brem;
  logic [1:0]     bh;
  logic [14:0]    bprod;
  logic [3:0]     btens;
  logic [7:0]     bones;
  logic [63:0]    spr, rot;
  logic [127:0]   spr2;
  logic           hit_w;
  logic [11:0]    loop_addr;

  ch8_ram #(.W(8), .D(ch8_pkg::MEM_BYTES)) u_mem (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata), .raddr(m_raddr), .rdata(m_q)
  );

  ch8_ram #(.W(ch8_pkg::SCREEN_W), .D(ch8_pkg::SCREEN_H)) u_disp (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata), .raddr(d_raddr), .rdata(d_q)
  );

  assign op_w    = {hi_r, m_q};
  assign x       = op_w[11:8];
  assign y       = op_w[7:4];
  assign nn      = op_w[7:0];
  assign nnn     = op_w[11:0];
  assign vx      = v_r[x];
  assign vy      = v_r[y];
  assign pc2     = pc_r + 12'd2;
  assign pc4     = pc_r + 12'd4;
  assign spm1    = sp_r - SPW'(1);
  assign pressed = key_down_r && (key_code_r == vx[3:0]);
  assign loop_addr = i_r[11:0] + 12'(cnt_r);

  ch8_alu u_alu (.n(op_w[3:0]), .vx(vx), .vy(vy), .res(alu));

  always_comb begin
    bx = v_r[op_r[11:8]];
    bh = (bx >= 8'd200) ? 2'd2 : ((bx >= 8'd100) ? 2'd1 : 2'd0);
    brem = bx - ((bh == 2'd2) ? 8'd200 : ((bh == 2'd1) ? 8'd100 : 8'd0));
    bprod = 15'(brem[6:0]) * 15'd205;
    btens = bprod[14:11];
    bones = brem - 8'(btens) * 8'd10;
    for (int c = 0; c < 8; c++) begin
      spr[c] = m_q[7 - c];
    end
    spr[63:8] = '0;
    spr2 = {spr, spr} << ox_r;
    rot = spr2[127:64];
    hit_w = hit_r | (|(d_q & rot));
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    cnt_nxt = cnt_r;
    pc_nxt = pc_r;
    i_nxt = i_r;
    dt_nxt = dt_r;
    st_nxt = st_r;
    sp_nxt = sp_r;
    stk_nxt = stk_r;
    v_nxt = v_r;
    hi_nxt = hi_r;
    op_nxt = op_r;
    key_down_nxt = key_down_r;
    key_code_nxt = key_code_r;
    rnd_nxt = rnd_r;
    px_nxt = px_r;
    ox_nxt = ox_r;
    oy_nxt = oy_r;
    hit_nxt = hit_r;
    status_nxt = status_r;
    lit_nxt = lit_r;
    drew_nxt = drew_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_pc_nxt = out_pc_r;
    out_status_nxt = out_status_r;
    out_lit_nxt = out_lit_r;
    out_snd_nxt = out_snd_r;
    out_drew_nxt = out_drew_r;
    m_we = 1'b0;
    m_waddr = loop_addr;
    m_wdata = v_r[cnt_r[3:0]];
    m_raddr = pc_r;
    d_we = 1'b0;
    d_waddr = oy_r + cnt_r;
    d_wdata = '0;
    d_raddr = oy_r + cnt_r;

    unique case (state_r)
      S_CLR: begin
        m_we = 1'b1;
        m_waddr = clr_r;
        m_wdata = (clr_r < 12'(ch8_pkg::FONT_LEN)) ? ch8_pkg::FONT_ROM[clr_r[6:0]] : 8'd0;
        d_we = (clr_r < 12'(ch8_pkg::SCREEN_H));
        d_waddr = clr_r[4:0];
        clr_nxt = clr_r + 12'd1;
        if (clr_r == 12'hFFF) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        d_raddr = in_pixel_y;
        if (in_valid) begin
          key_down_nxt = in_key_down;
          key_code_nxt = in_key_code;
          rnd_nxt = in_random_byte;
          px_nxt = in_pixel_x;
          status_nxt = ch8_pkg::ST_OK;
          lit_nxt = 1'b0;
          drew_nxt = 1'b0;
          unique case (in_cmd)
            ch8_pkg::CMD_LOAD: begin
              m_we = 1'b1;
              m_waddr = in_load_address;
              m_wdata = in_load_byte;
              state_nxt = S_DONE;
            end
            ch8_pkg::CMD_EXEC: state_nxt = S_F1;
            ch8_pkg::CMD_TICK: begin
              if (dt_r != 8'd0) dt_nxt = dt_r - 8'd1;
              if (st_r != 8'd0) st_nxt = st_r - 8'd1;
              state_nxt = S_DONE;
            end
            default: state_nxt = S_PIX;
          endcase
        end
      end
      S_PIX: begin
        lit_nxt = d_q[px_r];
        state_nxt = S_DONE;
      end
      S_F1: begin
        m_raddr = pc_r + 12'd1;
        hi_nxt = m_q;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        op_nxt = op_w;
        cnt_nxt = '0;
        hit_nxt = 1'b0;
        ox_nxt = vx[5:0];
        oy_nxt = vy[4:0];
        state_nxt = S_DONE;
        unique case (op_w[15:12]) inside
          4'h0: begin
            if (op_w == ch8_pkg::OP_CLS) begin
              drew_nxt = 1'b1;
              pc_nxt = pc2;
              state_nxt = S_CLS;
            end else if (op_w == ch8_pkg::OP_RET) begin
              if (sp_r == '0) begin
                status_nxt = ch8_pkg::ST_FAULT;
              end else begin
                sp_nxt = spm1;
                pc_nxt = stk_r[spm1[SIW-1:0]];
              end
            end else begin
              status_nxt = ch8_pkg::ST_BAD;
            end
          end
          4'h1: pc_nxt = nnn;
          4'h2: begin
            if (sp_r >= SPW'(STACK_DEPTH)) begin
              status_nxt = ch8_pkg::ST_FAULT;
            end else begin
              stk_nxt[sp_r[SIW-1:0]] = pc2;
              sp_nxt = sp_r + SPW'(1);
              pc_nxt = nnn;
            end
          end
          4'h3: pc_nxt = (vx == nn) ? pc4 : pc2;
          4'h4: pc_nxt = (vx != nn) ? pc4 : pc2;
          4'h5, 4'h9: begin
            if (op_w[3:0] != 4'h0) begin
              status_nxt = ch8_pkg::ST_BAD;
            end else begin
              pc_nxt = ((vx == vy) ^ op_w[15]) ? pc4 : pc2;
            end
          end
          4'h6: begin
            v_nxt[x] = nn;
            pc_nxt = pc2;
          end
          4'h7: begin
            v_nxt[x] = vx + nn;
            pc_nxt = pc2;
          end
          4'h8: begin
            if (alu.bad) begin
              status_nxt = ch8_pkg::ST_BAD;
            end else begin
              v_nxt[x] = alu.val;
              if (alu.vf_we) v_nxt[15] = alu.vf;
              pc_nxt = pc2;
            end
          end
          4'hA: begin
            i_nxt = {4'd0, nnn};
            pc_nxt = pc2;
          end
          4'hB: pc_nxt = nnn + 12'(v_r[0]);
          4'hC: begin
            v_nxt[x] = rnd_r & nn;
            pc_nxt = pc2;
          end
          4'hD: begin
            drew_nxt = 1'b1;
            pc_nxt = pc2;
            if (op_w[3:0] == 4'h0) begin
              v_nxt[15] = 8'd0;
            end else begin
              state_nxt = S_DRA;
            end
          end
          4'hE: begin
            if (nn == ch8_pkg::KEY_EQ) begin
              pc_nxt = pressed ? pc4 : pc2;
            end else if (nn == ch8_pkg::KEY_NE) begin
              pc_nxt = pressed ? pc2 : pc4;
            end else begin
              status_nxt = ch8_pkg::ST_BAD;
            end
          end
          default: begin
            pc_nxt = pc2;
            unique case (nn)
              ch8_pkg::F_GETDT: v_nxt[x] = dt_r;
              ch8_pkg::F_WAITK: begin
                if (!key_down_r) begin
                  status_nxt = ch8_pkg::ST_WAIT;
                  pc_nxt = pc_r;
                end else begin
                  v_nxt[x] = {4'd0, key_code_r};
                end
              end
              ch8_pkg::F_SETDT: dt_nxt = vx;
              ch8_pkg::F_SETST: st_nxt = vx;
              ch8_pkg::F_ADDI: i_nxt = i_r + 16'(vx);
              ch8_pkg::F_FONT: i_nxt = 16'(vx[3:0]) * 16'd5;
              ch8_pkg::F_BCD: state_nxt = S_BCD;
              ch8_pkg::F_STORE: state_nxt = S_ST;
              ch8_pkg::F_FETCH: state_nxt = S_LDA;
              default: begin
                status_nxt = ch8_pkg::ST_BAD;
                pc_nxt = pc_r;
              end
            endcase
          end
        endcase
      end
      S_CLS: begin
        d_we = 1'b1;
        d_waddr = cnt_r;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) state_nxt = S_DONE;
      end
      S_DRA: begin
        m_raddr = loop_addr;
        state_nxt = S_DRB;
      end
      S_DRB: begin
        d_we = 1'b1;
        d_wdata = d_q ^ rot;
        if (cnt_r[3:0] == op_r[3:0] - 4'd1) begin
          v_nxt[15] = {7'd0, hit_w};
          state_nxt = S_DONE;
        end else begin
          hit_nxt = hit_w;
          cnt_nxt = cnt_r + 5'd1;
          state_nxt = S_DRA;
        end
      end
      S_BCD: begin
        m_we = 1'b1;
        m_wdata = (cnt_r == 5'd0) ? {6'd0, bh} :
                  ((cnt_r == 5'd1) ? {4'd0, btens} : bones);
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd2) state_nxt = S_DONE;
      end
      S_ST: begin
        m_we = 1'b1;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r[3:0] == op_r[11:8]) begin
          i_nxt = i_r + 16'(op_r[11:8]) + 16'd1;
          state_nxt = S_DONE;
        end
      end
      S_LDA: begin
        m_raddr = loop_addr;
        state_nxt = S_LDB;
      end
      S_LDB: begin
        v_nxt[cnt_r[3:0]] = m_q;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r[3:0] == op_r[11:8]) begin
          i_nxt = i_r + 16'(op_r[11:8]) + 16'd1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_LDA;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_pc_nxt = pc_r;
          out_status_nxt = status_r;
          out_lit_nxt = lit_r;
          out_snd_nxt = (st_r != 8'd0);
          out_drew_nxt = drew_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase

    if (cfg_wr_en) begin
      pc_nxt = cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      pc_r <= 12'd512;
      i_r <= '0;
      dt_r <= '0;
      st_r <= '0;
      sp_r <= '0;
      for (int k = 0; k < STACK_DEPTH; k++) stk_r[k] <= '0;
      for (int k = 0; k < 16; k++) v_r[k] <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      pc_r <= pc_nxt;
      i_r <= i_nxt;
      dt_r <= dt_nxt;
      st_r <= st_nxt;
      sp_r <= sp_nxt;
      stk_r <= stk_nxt;
      v_r <= v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    hi_r <= hi_nxt;
    op_r <= op_nxt;
    key_down_r <= key_down_nxt;
    key_code_r <= key_code_nxt;
    rnd_r <= rnd_nxt;
    px_r <= px_nxt;
    ox_r <= ox_nxt;
    oy_r <= oy_nxt;
    hit_r <= hit_nxt;
    status_r <= status_nxt;
    lit_r <= lit_nxt;
    drew_r <= drew_nxt;
    out_pc_r <= out_pc_nxt;
    out_status_r <= out_status_nxt;
    out_lit_r <= out_lit_nxt;
    out_snd_r <= out_snd_nxt;
    out_drew_r <= out_drew_nxt;
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_pc = out_pc_r;
  assign out_status = out_status_r;
  assign out_pixel_lit = out_lit_r;
  assign out_sound_active = out_snd_r;
  assign out_display_changed = out_drew_r;

endmodule

[rtl/ch8_ram.sv]
`timescale 1ns / 1ps

module ch8_ram #(
  parameter int W = 8,
  parameter int D = 4096
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/ch8_alu.sv]
`timescale 1ns / 1ps

module ch8_alu (
  input  logic [3:0]        n,
  input  logic [7:0]        vx,
  input  logic [7:0]        vy,
  output ch8_pkg::alu_res_t res
);

  logic [8:0] sum;

  always_comb begin
    sum = {1'b0, vx} + {1'b0, vy};
    res = '0;
    unique case (n)
      4'h0: res.val = vy;
      4'h1: res.val = vx | vy;
      4'h2: res.val = vx & vy;
      4'h3: res.val = vx ^ vy;
      4'h4: begin
        res.val = sum[7:0];
        res.vf = {7'd0, sum[8]};
        res.vf_we = 1'b1;
      end
      4'h5: begin
        res.val = vx - vy;
        res.vf = {7'd0, vx >= vy};
        res.vf_we = 1'b1;
      end
      4'h6: begin
        res.val = {1'b0, vx[7:1]};
        res.vf = {7'd0, vx[0]};
        res.vf_we = 1'b1;
      end
      4'h7: begin
        res.val = vy - vx;
        res.vf = {7'd0, vy >= vx};
        res.vf_we = 1'b1;
      end
      4'hE: begin
        res.val = {vx[6:0], 1'b0};
        res.vf = {7'd0, vx[7]};
        res.vf_we = 1'b1;
      end
      default: res.bad = 1'b1;
    endcase
  end

endmodule

[rtl/ch8_checker.sv]
`timescale 1ns / 1ps

module ch8_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] out_pc,
  input logic [1:0]  out_status,
  input logic        out_pixel_lit,
  input logic        out_display_changed
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result valid straight after reset.");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pc) && $stable(out_status))
    else $error("Stalled result changed.");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Second transaction taken while one is in progress.");

  a_pix_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pixel_lit |-> out_status == ch8_pkg::ST_OK && !out_display_changed)
    else $error("Pixel read reported with an instruction outcome.");

  a_fail_nodraw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ch8_pkg::ST_OK |-> !out_display_changed)
    else $error("Failed instruction reported a display change.");

endmodule

bind chip8_cpu_step ch8_checker u_ch8_checker (.*);

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int DEPTH = 16;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [11:0] addr;
    logic [7:0]  data;
    logic        kd;
    logic [3:0]  kc;
    logic [7:0]  rnd;
    logic [5:0]  px;
    logic [4:0]  py;
  } item_t;

  typedef struct packed {
    logic [11:0] pc;
    logic [1:0]  status;
    logic        lit;
    logic        snd;
    logic        chg;
  } res_t;

  class ch8_scoreboard;
    logic [7:0]  mem [ch8_pkg::MEM_BYTES];
    logic        disp [ch8_pkg::SCREEN_W * ch8_pkg::SCREEN_H];
    logic [7:0]  v [16];
    logic [11:0] stk [16];
    int          sp;
    logic [11:0] pc;
    logic [15:0] ir;
    logic [7:0]  dt, st;
    res_t        awaited [$];
    int          errors;
    int          checked;

    function new();
      for (int i = 0; i < ch8_pkg::MEM_BYTES; i++)
        mem[i] = (i < ch8_pkg::FONT_LEN) ? ch8_pkg::FONT_ROM[i] : 8'h00;
      for (int i = 0; i < ch8_pkg::SCREEN_W * ch8_pkg::SCREEN_H; i++) disp[i] = 1'b0;
      for (int i = 0; i < 16; i++) begin
        v[i] = 8'h00;
        stk[i] = 12'h000;
      end
      sp = 0;
      pc = 12'd512;
      ir = 16'h0000;
      dt = 8'h00;
      st = 8'h00;
      errors = 0;
      checked = 0;
    endfunction

    function void set_start(logic [11:0] a);
      pc = a;
    endfunction

    function logic [1:0] run_instr(item_t it, output logic drew);
      logic [15:0] op;
      logic [3:0]  x, y, n;
      logic [7:0]  nn, vx, vy, row;
      logic [11:0] nnn, nxt, skp, npc, a;
      logic [8:0]  sum;
      logic        hit, pressed;
      logic [4:0]  ry;
      logic [5:0]  rx;
      drew = 1'b0;
      op = {mem[pc], mem[12'(pc + 12'd1)]};
      x = op[11:8];
      y = op[7:4];
      n = op[3:0];
      nn = op[7:0];
      nnn = op[11:0];
      vx = v[x];
      vy = v[y];
      nxt = pc + 12'd2;
      skp = pc + 12'd4;
      npc = nxt;
      case (op[15:12])
        4'h0: begin
          if (op == ch8_pkg::OP_CLS) begin
            for (int i = 0; i < ch8_pkg::SCREEN_W * ch8_pkg::SCREEN_H; i++) disp[i] = 1'b0;
            drew = 1'b1;
          end else if (op == ch8_pkg::OP_RET) begin
            if (sp == 0) return ch8_pkg::ST_FAULT;
            sp--;
            npc = stk[sp];
          end else return ch8_pkg::ST_BAD;
        end
        4'h1: npc = nnn;
        4'h2: begin
          if (sp >= DEPTH) return ch8_pkg::ST_FAULT;
          stk[sp] = nxt;
          sp++;
          npc = nnn;
        end
        4'h3: npc = (vx == nn) ? skp : nxt;
        4'h4: npc = (vx != nn) ? skp : nxt;
        4'h5: begin
          if (n != 0) return ch8_pkg::ST_BAD;
          npc = (vx == vy) ? skp : nxt;
        end
        4'h6: v[x] = nn;
        4'h7: v[x] = vx + nn;
        4'h8: begin
          case (n)
            4'h0: v[x] = vy;
            4'h1: v[x] = vx | vy;
            4'h2: v[x] = vx & vy;
            4'h3: v[x] = vx ^ vy;
            4'h4: begin
              sum = vx + vy;
              v[x] = sum[7:0];
              v[15] = {7'b0, sum[8]};
            end
            4'h5: begin
              v[x] = vx - vy;
              v[15] = {7'b0, vx >= vy};
            end
            4'h6: begin
              v[x] = vx >> 1;
              v[15] = {7'b0, vx[0]};
            end
            4'h7: begin
              v[x] = vy - vx;
              v[15] = {7'b0, vy >= vx};
            end
            4'hE: begin
              v[x] = vx << 1;
              v[15] = {7'b0, vx[7]};
            end
            default: return ch8_pkg::ST_BAD;
          endcase
        end
        4'h9: begin
          if (n != 0) return ch8_pkg::ST_BAD;
          npc = (vx != vy) ? skp : nxt;
        end
        4'hA: ir = {4'h0, nnn};
        4'hB: npc = 12'(v[0] + nnn);
        4'hC: v[x] = it.rnd & nn;
        4'hD: begin
          hit = 1'b0;
          for (int r = 0; r < n; r++) begin
            row = mem[12'(ir[11:0] + r)];
            ry = 5'(vy[4:0] + r);
            for (int c = 0; c < 8; c++) begin
              if (row[7 - c]) begin
                rx = 6'(vx[5:0] + c);
                if (disp[{ry, rx}]) hit = 1'b1;
                disp[{ry, rx}] = ~disp[{ry, rx}];
              end
            end
          end
          v[15] = {7'b0, hit};
          drew = 1'b1;
        end
        4'hE: begin
          pressed = it.kd && (it.kc == vx[3:0]);
          if (nn == ch8_pkg::KEY_EQ) npc = pressed ? skp : nxt;
          else if (nn == ch8_pkg::KEY_NE) npc = pressed ? nxt : skp;
          else return ch8_pkg::ST_BAD;
        end
        default: begin
          case (nn)
            ch8_pkg::F_GETDT: v[x] = dt;
            ch8_pkg::F_WAITK: begin
              if (!it.kd) return ch8_pkg::ST_WAIT;
              v[x] = {4'h0, it.kc};
            end
            ch8_pkg::F_SETDT: dt = vx;
            ch8_pkg::F_SETST: st = vx;
            ch8_pkg::F_ADDI: ir = ir + vx;
            ch8_pkg::F_FONT: ir = 16'(vx[3:0] * 5);
            ch8_pkg::F_BCD: begin
              mem[ir[11:0]] = vx / 100;
              mem[12'(ir[11:0] + 1)] = (vx / 10) % 10;
              mem[12'(ir[11:0] + 2)] = vx % 10;
            end
            ch8_pkg::F_STORE: begin
              for (int r = 0; r <= x; r++) begin
                a = 12'(ir[11:0] + r);
                mem[a] = v[r];
              end
              ir = ir + x + 16'd1;
            end
            ch8_pkg::F_FETCH: begin
              for (int r = 0; r <= x; r++) begin
                a = 12'(ir[11:0] + r);
                v[r] = mem[a];
              end
              ir = ir + x + 16'd1;
            end
            default: return ch8_pkg::ST_BAD;
          endcase
        end
      endcase
      pc = npc;
      return ch8_pkg::ST_OK;
    endfunction

    function void note_input(item_t it);
      res_t r;
      logic drew;
      r = '0;
      case (it.cmd)
        ch8_pkg::CMD_LOAD: mem[it.addr] = it.data;
        ch8_pkg::CMD_EXEC: begin
          r.status = run_instr(it, drew);
          r.chg = drew;
        end
        ch8_pkg::CMD_TICK: begin
          if (dt != 0) dt--;
          if (st != 0) st--;
        end
        default: r.lit = disp[{it.py, it.px}];
      endcase
      r.pc = pc;
      r.snd = (st != 0);
      awaited.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t want;
      checked++;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result transaction: %p", got);
        return;
      end
      want = awaited.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("Mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        cfg_wr_en;
  logic [11:0] cfg_wr_data;
  logic        in_valid, in_ready;
  logic [1:0]  in_cmd;
  logic [11:0] in_load_address;
  logic [7:0]  in_load_byte;
  logic        in_key_down;
  logic [3:0]  in_key_code;
  logic [7:0]  in_random_byte;
  logic [5:0]  in_pixel_x;
  logic [4:0]  in_pixel_y;
  logic        out_valid, out_ready;
  logic [11:0] out_pc;
  logic [1:0]  out_status;
  logic        out_pixel_lit, out_sound_active, out_display_changed;

  ch8_scoreboard sb;
  bit calm;
  bit held;

  chip8_cpu_step #(.STACK_DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_cmd(in_cmd), .in_load_address(in_load_address), .in_load_byte(in_load_byte),
    .in_key_down(in_key_down), .in_key_code(in_key_code),
    .in_random_byte(in_random_byte), .in_pixel_x(in_pixel_x), .in_pixel_y(in_pixel_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pc(out_pc), .out_status(out_status), .out_pixel_lit(out_pixel_lit),
    .out_sound_active(out_sound_active), .out_display_changed(out_display_changed)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic item_t make_item(logic [1:0] cmd);
    item_t it;
    it = item_t'({$urandom, $urandom});
    it.cmd = cmd;
    return it;
  endfunction

  task automatic send(item_t it);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= it.cmd;
    in_load_address <= it.addr;
    in_load_byte <= it.data;
    in_key_down <= it.kd;
    in_key_code <= it.kc;
    in_random_byte <= it.rnd;
    in_pixel_x <= it.px;
    in_pixel_y <= it.py;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
  endtask

  task automatic load_byte(logic [11:0] a, logic [7:0] d);
    item_t it;
    it = make_item(ch8_pkg::CMD_LOAD);
    it.addr = a;
    it.data = d;
    send(it);
  endtask

  task automatic execute(logic kd, logic [3:0] kc);
    item_t it;
    it = make_item(ch8_pkg::CMD_EXEC);
    it.kd = kd;
    it.kc = kc;
    send(it);
  endtask

  task automatic run_op(logic [15:0] op, logic kd, logic [3:0] kc);
    load_byte(sb.pc, op[15:8]);
    load_byte(sb.pc + 12'd1, op[7:0]);
    execute(kd, kc);
  endtask

  task automatic read_pixel(logic [5:0] x, logic [4:0] y);
    item_t it;
    it = make_item(ch8_pkg::CMD_PIX);
    it.px = x;
    it.py = y;
    send(it);
  endtask

  task automatic write_start(logic [11:0] a);
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= a;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_start(a);
  endtask

  function automatic logic [15:0] pick_op(output logic kd, output logic [3:0] kc);
    logic [15:0] op;
    logic [7:0] fsub [9];
    fsub = '{ch8_pkg::F_GETDT, ch8_pkg::F_WAITK, ch8_pkg::F_SETDT, ch8_pkg::F_SETST,
             ch8_pkg::F_ADDI, ch8_pkg::F_FONT, ch8_pkg::F_BCD, ch8_pkg::F_STORE,
             ch8_pkg::F_FETCH};
    op = 16'($urandom);
    kd = $urandom_range(0, 1);
    kc = $urandom_range(0, 15);
    if ($urandom_range(0, 19) == 0) return op;
    case (op[15:12])
      4'h0: op = ($urandom_range(0, 2) == 0) ? ch8_pkg::OP_CLS : ch8_pkg::OP_RET;
      4'h5, 4'h9: op[3:0] = 4'h0;
      4'h8: if (op[3:0] > 4'h7) op[3:0] = 4'hE;
      4'hE: begin
        op[7:0] = op[0] ? ch8_pkg::KEY_EQ : ch8_pkg::KEY_NE;
        if (op[1]) kc = sb.v[op[11:8]][3:0];
      end
      4'hF: op[7:0] = fsub[$urandom_range(0, 8)];
      default: ;
    endcase
    return op;
  endfunction

  task automatic random_phase(int count, bit last);
    logic [15:0] op;
    logic kd;
    logic [3:0] kc;
    int pick;
    item_t it;
    for (int i = 0; i < count; i += 1) begin
      if (last && count - i < 250) calm = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        op = pick_op(kd, kc);
        run_op(op, kd, kc);
        i += 2;
      end else if (pick < 80) begin
        execute($urandom_range(0, 1), $urandom_range(0, 15));
      end else if (pick < 88) begin
        send(make_item(ch8_pkg::CMD_TICK));
      end else if (pick < 95) begin
        send(make_item(ch8_pkg::CMD_PIX));
      end else begin
        send(make_item(ch8_pkg::CMD_LOAD));
      end
    end
  endtask

  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!calm && !held && sb.checked >= 300) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (600) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result('{out_pc, out_status, out_pixel_lit, out_sound_active,
                        out_display_changed});
  end

  initial begin
    sb = new();
    calm = 1'b0;
    held = 1'b0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 12'd0;
    in_valid = 1'b0;
    in_cmd = ch8_pkg::CMD_LOAD;
    in_load_address = '0;
    in_load_byte = '0;
    in_key_down = 1'b0;
    in_key_code = '0;
    in_random_byte = '0;
    in_pixel_x = '0;
    in_pixel_y = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (4200) @(posedge clk);
    write_start(12'd512);

    run_op(16'hA000, 1'b0, 4'h0);
    run_op(16'h6A3E, 1'b0, 4'h0);
    run_op(16'h6B1F, 1'b0, 4'h0);
    run_op(16'hDAB5, 1'b0, 4'h0);
    read_pixel(6'd63, 5'd31);
    read_pixel(6'd0, 5'd0);
    run_op(16'hDAB5, 1'b0, 4'h0);
    run_op(16'hDAB0, 1'b0, 4'h0);
    run_op(16'hFA0A, 1'b0, 4'h0);
    execute(1'b1, 4'hF);
    run_op(16'hEA9E, 1'b1, 4'hF);
    run_op(16'h8AB4, 1'b0, 4'h0);
    run_op(ch8_pkg::OP_CLS, 1'b0, 4'h0);
    run_op(16'h0123, 1'b0, 4'h0);
    run_op(ch8_pkg::OP_RET, 1'b0, 4'h0);

    write_start(12'd4095);
    load_byte(12'd4095, 8'h2F);
    load_byte(12'd0, 8'hFF);
    repeat (DEPTH + 1) execute(1'b0, 4'h0);
    load_byte(12'd4095, 8'h00);
    load_byte(12'd0, 8'hEE);
    repeat (DEPTH + 1) execute(1'b0, 4'h0);
    random_phase(450, 1'b0);

    write_start(12'd0);
    random_phase(450, 1'b0);
    write_start(12'($urandom));
    random_phase(450, 1'b0);
    write_start(12'd512);
    random_phase(450, 1'b1);

    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
